### hw/rtl/nearest_point_search_3d_defines.svh
// Assertion macros used by the checker of the nearest point search block.
`ifndef NEAREST_POINT_SEARCH_3D_DEFINES_SVH
`define NEAREST_POINT_SEARCH_3D_DEFINES_SVH

// Same-cycle implication.
`define NPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/nps_pkg.sv
package nps_pkg;

   localparam int MAX_POINTS = 256;
   localparam int COORD_BITS = 16;
   localparam int IDX_BITS   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int DIST_BITS  = 2 * COORD_BITS + 2;

   localparam int FIELD_COORD_BITS = 16;
   localparam int FIELD_INDEX_BITS = 8;
   localparam int FIELD_COUNT_BITS = 9;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_QUERY  = 2'd2,
      OP_HEIGHT = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic signed [COORD_BITS-1:0] z;
   } point_type;

   typedef struct packed {
      logic                valid;
      logic                last;
      logic [IDX_BITS-1:0] index;
   } meta_type;

   typedef struct packed {
      meta_type  meta;
      point_type pt;
   } sample_type;

   typedef struct packed {
      meta_type             meta;
      logic [DIST_BITS-1:0] sq_sum;
   } dist_type;

endpackage

### hw/rtl/nps_if.sv
interface nps_req_if;
   logic                                         valid;
   logic                                         ready;
   logic [1:0]                                   opcode;
   logic signed [nps_pkg::FIELD_COORD_BITS-1:0]  x_coord;
   logic signed [nps_pkg::FIELD_COORD_BITS-1:0]  y_coord;
   logic signed [nps_pkg::FIELD_COORD_BITS-1:0]  z_coord;

   modport source (output valid, output opcode, output x_coord, output y_coord,
                   output z_coord, input ready);
   modport sink (input valid, input opcode, input x_coord, input y_coord,
                 input z_coord, output ready);
endinterface

interface nps_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            status;
   logic [nps_pkg::FIELD_INDEX_BITS-1:0]  closest_index;
   logic [nps_pkg::FIELD_COUNT_BITS-1:0]  point_count;

   modport source (output valid, output status, output closest_index,
                   output point_count, input ready);
   modport sink (input valid, input status, input closest_index,
                 input point_count, output ready);
endinterface

### hw/rtl/nps_ram.sv
module nps_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/nps_dist.sv
// Squared distance unit: squares, then sum. Two register stages.
module nps_dist (
   input  logic                clock,
   input  logic                reset,
   input  nps_pkg::sample_type smp_i,
   input  nps_pkg::point_type  query_i,
   output nps_pkg::dist_type   dist_o
);

   localparam int CB = nps_pkg::COORD_BITS;

   logic signed [CB:0]   diff    [3];
   logic [CB:0]          mag_full[3];
   logic [CB-1:0]        mag     [3];
   logic [2*CB-1:0]      sq_in   [3];
   logic [2*CB-1:0]      sq_ff   [3];
   logic [nps_pkg::DIST_BITS-1:0] sum_in, sum_ff;
   nps_pkg::meta_type    meta1_ff, meta2_ff;

   always_comb begin
      diff[0] = (CB+1)'(smp_i.pt.x) - (CB+1)'(query_i.x);
      diff[1] = (CB+1)'(smp_i.pt.y) - (CB+1)'(query_i.y);
      diff[2] = (CB+1)'(smp_i.pt.z) - (CB+1)'(query_i.z);
      for (int i = 0; i < 3; i++) begin
         mag_full[i] = diff[i][CB] ? -diff[i] : diff[i];
         mag[i]      = mag_full[i][CB-1:0];
         sq_in[i]    = mag[i] * mag[i];
      end
      sum_in = nps_pkg::DIST_BITS'(sq_ff[0]) + nps_pkg::DIST_BITS'(sq_ff[1])
             + nps_pkg::DIST_BITS'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= sq_in[i];
      end
      sum_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta1_ff <= '0;
         meta2_ff <= '0;
      end else begin
         meta1_ff <= smp_i.meta;
         meta2_ff <= meta1_ff;
      end
   end

   assign dist_o.meta   = meta2_ff;
   assign dist_o.sq_sum = sum_ff;

endmodule

### hw/rtl/nearest_point_search_3d.sv
// Add, clear, height update and empty query go from S_IDLE to S_DONE, then the response is
// registered once the output is free. Query: S_SCAN issues one stored point per cycle through
// the shared distance unit fed by one read port of the point memories, then S_WAIT takes the
// last distance and goes on to S_DONE. One transaction at a time: not ready until its response
// is registered, so no new transaction is taken before the last one is through.
// Reset clears point count, height mark and response valid; memory contents stay.
module nearest_point_search_3d (
   input logic        clock,
   input logic        reset,
   nps_req_if.sink    req_chan,
   nps_rsp_if.source  rsp_chan
);

   localparam int CB = nps_pkg::COORD_BITS;
   localparam int IB = nps_pkg::IDX_BITS;
   localparam int NB = nps_pkg::CNT_BITS;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_WAIT = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [NB-1:0]  count_ff, count_in;
   logic [NB-1:0]  height_mark_ff, height_mark_in;
   logic [CB-1:0]  height_val_ff, height_val_in;
   nps_pkg::point_type query_ff, query_in, req_pt;
   logic [IB-1:0]  scan_idx_ff, scan_idx_in;
   nps_pkg::meta_type rd_meta_ff, rd_meta_in;
   logic [nps_pkg::DIST_BITS-1:0] best_dist_ff, best_dist_in;
   logic [IB-1:0]  best_idx_ff, best_idx_in;
   logic [1:0]     res_status_ff, res_status_in;
   logic [IB-1:0]  res_idx_ff, res_idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [IB-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [NB-1:0]  rsp_count_ff, rsp_count_in;

   logic           accept, wr_en, last_issue, take, out_free;
   logic [IB-1:0]  take_idx;
   logic [CB-1:0]  ram_x, ram_y, ram_z;
   nps_pkg::sample_type smp;
   nps_pkg::dist_type   dist_res;

   assign req_pt.x = CB'(req_chan.x_coord);
   assign req_pt.y = CB'(req_chan.y_coord);
   assign req_pt.z = CB'(req_chan.z_coord);

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign wr_en  = accept && (nps_pkg::opcode_type'(req_chan.opcode) == nps_pkg::OP_ADD)
                   && (count_ff < NB'(nps_pkg::MAX_POINTS));
   assign last_issue = (NB'(scan_idx_ff) == count_ff - NB'(1));
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;

   nps_ram #(.WIDTH(CB), .DEPTH(nps_pkg::MAX_POINTS)) u_ram_x (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[IB-1:0]), .wr_data(req_pt.x),
      .rd_en(state_ff == S_SCAN), .rd_addr(scan_idx_ff), .rd_data(ram_x)
   );
   nps_ram #(.WIDTH(CB), .DEPTH(nps_pkg::MAX_POINTS)) u_ram_y (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[IB-1:0]), .wr_data(req_pt.y),
      .rd_en(state_ff == S_SCAN), .rd_addr(scan_idx_ff), .rd_data(ram_y)
   );
   nps_ram #(.WIDTH(CB), .DEPTH(nps_pkg::MAX_POINTS)) u_ram_z (
      .clock(clock), .wr_en(wr_en), .wr_addr(count_ff[IB-1:0]), .wr_data(req_pt.z),
      .rd_en(state_ff == S_SCAN), .rd_addr(scan_idx_ff), .rd_data(ram_z)
   );

   // entries below the height mark carry the last broadcast height
   always_comb begin
      smp.meta = rd_meta_ff;
      smp.pt.x = ram_x;
      smp.pt.y = (NB'(rd_meta_ff.index) < height_mark_ff) ? height_val_ff : ram_y;
      smp.pt.z = ram_z;
   end

   nps_dist u_dist (
      .clock(clock), .reset(reset), .smp_i(smp), .query_i(query_ff), .dist_o(dist_res)
   );

   // later index wins on a tie
   assign take     = (dist_res.meta.index == '0) || (dist_res.sq_sum <= best_dist_ff);
   assign take_idx = take ? dist_res.meta.index : best_idx_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      height_mark_in = height_mark_ff;
      height_val_in  = height_val_ff;
      query_in       = query_ff;
      scan_idx_in    = scan_idx_ff;
      rd_meta_in     = '0;
      best_dist_in   = best_dist_ff;
      best_idx_in    = best_idx_ff;
      res_status_in  = res_status_ff;
      res_idx_in     = res_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_count_in   = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_status_in = nps_pkg::ST_OK;
               res_idx_in    = '0;
               state_in      = S_DONE;
               unique case (nps_pkg::opcode_type'(req_chan.opcode))
                  nps_pkg::OP_ADD: begin
                     if (count_ff >= NB'(nps_pkg::MAX_POINTS)) begin
                        res_status_in = nps_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + NB'(1);
                     end
                  end
                  nps_pkg::OP_CLEAR: begin
                     count_in       = '0;
                     height_mark_in = '0;
                  end
                  nps_pkg::OP_HEIGHT: begin
                     height_mark_in = count_ff;
                     height_val_in  = req_pt.y;
                  end
                  nps_pkg::OP_QUERY: begin
                     query_in = req_pt;
                     if (count_ff == '0) begin
                        res_status_in = nps_pkg::ST_EMPTY;
                     end else begin
                        scan_idx_in = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_meta_in.valid = 1'b1;
            rd_meta_in.last  = last_issue;
            rd_meta_in.index = scan_idx_ff;
            scan_idx_in      = scan_idx_ff + IB'(1);
            if (last_issue) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (dist_res.meta.valid && dist_res.meta.last) begin
               res_status_in = nps_pkg::ST_OK;
               res_idx_in    = take_idx;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (dist_res.meta.valid) begin
         best_dist_in = take ? dist_res.sq_sum : best_dist_ff;
         best_idx_in  = take_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         height_mark_ff <= '0;
         rd_meta_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         height_mark_ff <= height_mark_in;
         rd_meta_ff     <= rd_meta_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      height_val_ff <= height_val_in;
      query_ff      <= query_in;
      scan_idx_ff   <= scan_idx_in;
      best_dist_ff  <= best_dist_in;
      best_idx_ff   <= best_idx_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.closest_index = nps_pkg::FIELD_INDEX_BITS'(rsp_idx_ff);
   assign rsp_chan.point_count   = nps_pkg::FIELD_COUNT_BITS'(rsp_count_ff);

endmodule

### hw/rtl/nps_checker.sv
`include "nearest_point_search_3d_defines.svh"

module nps_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [1:0]                            rsp_status,
   input logic [nps_pkg::FIELD_INDEX_BITS-1:0]  rsp_closest_index,
   input logic [nps_pkg::FIELD_COUNT_BITS-1:0]  rsp_point_count
);

   `NPS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready after accepted transaction")
   `NPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_closest_index) && $stable(rsp_point_count), "stalled response changed")
   `NPS_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && (rsp_status == nps_pkg::ST_FULL), rsp_point_count == nps_pkg::FIELD_COUNT_BITS'(nps_pkg::MAX_POINTS), "full status with table not full")
   `NPS_ASSERT_NOW(a_empty_fields, clock, reset, rsp_valid && (rsp_status == nps_pkg::ST_EMPTY), (rsp_point_count == '0) && (rsp_closest_index == '0), "empty status with points or index")

endmodule

bind nearest_point_search_3d nps_checker u_nps_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_status(rsp_chan.status),
   .rsp_closest_index(rsp_chan.closest_index),
   .rsp_point_count(rsp_chan.point_count)
);
